>>> rtl/scpf_pkg.sv
// Shared types and constants for the scanline pixel format converter.
// No dependencies; used by every module of the block.
package scpf_pkg;

    typedef enum logic [1:0] {
        FMT_XRGB32 = 2'd0,
        FMT_RGB24  = 2'd1,
        FMT_RGB565 = 2'd2,
        FMT_RGB555 = 2'd3
    } fmt_t;

    localparam logic [0:0]  REG_PIXEL_FORMAT = 1'b0;
    localparam logic [0:0]  REG_LINE_WIDTH   = 1'b1;

    localparam logic [13:0] LINE_WIDTH_RESET = 14'd1024;
    localparam logic [7:0]  ALPHA_OPAQUE     = 8'hFF;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] fourth;
    } pixel_t;

    // Up to two pixels produced by one source word.
    typedef struct packed {
        pixel_t px0;
        pixel_t px1;
        logic   le0;    // line end on first pixel
        logic   le1;    // line end on second pixel
        logic   two;    // second pixel present
    } pair_t;

endpackage

>>> rtl/scpf_decode.sv
// Word decoder: unpacks one source word into up to two XRGB pixels.
// Handles 24-bit byte carry. Depends on scpf_pkg.
module scpf_decode (
    input  logic [31:0]          word,
    input  scpf_pkg::fmt_t       fmt,
    input  logic [15:0]          carry_bytes,
    input  logic [1:0]           carry_count,
    output scpf_pkg::pixel_t     px0,
    output scpf_pkg::pixel_t     px1,
    output logic                 made_two,
    output logic [15:0]          carry_bytes_next,
    output logic [1:0]           carry_count_next
);

    function automatic scpf_pkg::pixel_t expand_565(input logic [7:0] lo, input logic [7:0] hi);
        scpf_pkg::pixel_t p;
        p.blue   = {lo[4:0], 3'b000};
        p.green  = {hi[2:0], lo[7:5], 2'b00};
        p.red    = {hi[7:3], 3'b000};
        p.fourth = scpf_pkg::ALPHA_OPAQUE;
        return p;
    endfunction

    function automatic scpf_pkg::pixel_t expand_555(input logic [7:0] lo, input logic [7:0] hi);
        scpf_pkg::pixel_t p;
        p.blue   = {lo[4:0], 3'b000};
        p.green  = {hi[1:0], lo[7:5], 3'b000};
        p.red    = {hi[6:2], 3'b000};
        p.fourth = scpf_pkg::ALPHA_OPAQUE;
        return p;
    endfunction

    logic [7:0] b0, b1, b2, b3, c0, c1;

    assign b0 = word[7:0];
    assign b1 = word[15:8];
    assign b2 = word[23:16];
    assign b3 = word[31:24];
    assign c0 = carry_bytes[7:0];
    assign c1 = carry_bytes[15:8];

    always_comb
    begin
        px0              = '{blue: b0, green: b1, red: b2, fourth: b3};
        px1              = px0;
        made_two         = 1'b0;
        carry_bytes_next = 16'h0000;
        carry_count_next = 2'd0;
        case (fmt)
            scpf_pkg::FMT_XRGB32:
            begin
                px0 = '{blue: b0, green: b1, red: b2, fourth: b3};
            end
            scpf_pkg::FMT_RGB24:
            begin
                case (carry_count)
                    2'd0:
                    begin
                        px0              = '{blue: b0, green: b1, red: b2,
                                             fourth: scpf_pkg::ALPHA_OPAQUE};
                        carry_bytes_next = {8'h00, b3};
                        carry_count_next = 2'd1;
                    end
                    2'd1:
                    begin
                        px0              = '{blue: c0, green: b0, red: b1,
                                             fourth: scpf_pkg::ALPHA_OPAQUE};
                        carry_bytes_next = {b3, b2};
                        carry_count_next = 2'd2;
                    end
                    default:
                    begin
                        // two bytes held: two whole pixels, nothing left over
                        px0      = '{blue: c0, green: c1, red: b0,
                                     fourth: scpf_pkg::ALPHA_OPAQUE};
                        px1      = '{blue: b1, green: b2, red: b3,
                                     fourth: scpf_pkg::ALPHA_OPAQUE};
                        made_two = 1'b1;
                    end
                endcase
            end
            scpf_pkg::FMT_RGB565:
            begin
                px0      = expand_565(b0, b1);
                px1      = expand_565(b2, b3);
                made_two = 1'b1;
            end
            default:
            begin
                px0      = expand_555(b0, b1);
                px1      = expand_555(b2, b3);
                made_two = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/scpf_serial.sv
// Result register and pixel serializer: holds one or two pixels of a word
// and sends them out one transfer at a time. Depends on scpf_pkg.
module scpf_serial (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  scpf_pkg::pair_t      load_pair,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_stall,
    output scpf_pkg::pixel_t     out_pixel,
    output logic                 out_line_end,
    output logic                 out_burst_last
);

    logic             busy_reg, busy_next;
    logic             sel_reg, sel_next;
    scpf_pkg::pair_t  pair_reg;
    logic             last;
    logic             xfer;

    assign last           = sel_reg | ~pair_reg.two;
    assign xfer           = busy_reg & ~out_stall;
    assign free           = ~busy_reg | (xfer & last);

    assign out_valid      = busy_reg;
    assign out_pixel      = sel_reg ? pair_reg.px1 : pair_reg.px0;
    assign out_line_end   = sel_reg ? pair_reg.le1 : pair_reg.le0;
    assign out_burst_last = last;

    always_comb
    begin
        busy_next = busy_reg;
        sel_next  = sel_reg;
        if (xfer)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                sel_next = 1'b1;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            sel_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sel_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            sel_reg  <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pair_reg <= load_pair;
        end
    end

endmodule

>>> rtl/scanline_pixel_format_converter.sv
// Top level of the scanline pixel format converter: config registers, input
// register, line state and pixel counting. Uses scpf_pkg, scpf_decode, scpf_serial.
//
// Takes one 32-bit little-endian source word per transfer and emits 32-bit
// pixels (blue, green, red, fourth byte), one per output transfer. Formats:
// passthrough 32-bit (1 pixel/word), packed 24-bit (1 or 2 pixels/word, bytes
// carried between words), 5-6-5 and 5-5-5 (2 pixels/word, channels expanded
// with zero low bits, fourth byte 0xFF). Raise line_start on the first word
// of each scanline; after line_width pixels (clamped to MAX_LINE_WIDTH) the
// last pixel carries line_end and further words of that line are dropped.
// burst_last marks the last pixel from each word. Timing: a word sits in the
// input register, is decoded and lands in the result register; a new word is
// taken every cycle while words yield one pixel each and out_stall is low. The
// single output port is the limit: a word yielding two pixels occupies the
// output for two transfers, so two-pixel formats take a new word only once
// both pixels of the previous word are sent. Words yielding no pixel (line already complete) are dropped.
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be issued while the block is idle.
module scanline_pixel_format_converter #(
    parameter int MAX_LINE_WIDTH = 8192
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,

    // source word channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] source_word,
    input  logic        line_start,

    // pixel channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  blue_value,
    output logic [7:0]  green_value,
    output logic [7:0]  red_value,
    output logic [7:0]  fourth_byte,
    output logic        line_end,
    output logic        burst_last
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    scpf_pkg::fmt_t  pixel_format_reg;
    logic [13:0]     line_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= scpf_pkg::FMT_XRGB32;
            line_width_reg   <= scpf_pkg::LINE_WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                scpf_pkg::REG_PIXEL_FORMAT: pixel_format_reg <= scpf_pkg::fmt_t'(cfg_data[1:0]);
                scpf_pkg::REG_LINE_WIDTH:   line_width_reg   <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // Effective line width; widths above the limit act as the limit.
    logic [13:0] limit;
    assign limit = (int'(line_width_reg) > MAX_LINE_WIDTH) ? 14'(MAX_LINE_WIDTH)
                                                           : line_width_reg;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic        s1_valid_reg, s1_valid_next;
    logic [31:0] s1_word_reg;
    logic        s1_start_reg;
    logic        s1_adv;       // word in input register is consumed this cycle
    logic        ser_free;
    logic        in_xfer;

    assign s1_adv   = s1_valid_reg & ser_free;
    assign in_stall = s1_valid_reg & ~ser_free;
    assign in_xfer  = in_valid & ~in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_word_reg  <= source_word;
            s1_start_reg <= line_start;
        end
    end

    // ------------------------------------------------------------------
    // Line state: 24-bit carry and pixel count
    // ------------------------------------------------------------------
    logic [15:0] carry_bytes_reg, carry_bytes_next;
    logic [1:0]  carry_count_reg, carry_count_next;
    logic [13:0] pixels_done_reg, pixels_done_next;

    // line_start clears carry and count before the word is used
    logic [15:0] carry_bytes_cur;
    logic [1:0]  carry_count_cur;
    logic [13:0] pd_cur;

    assign carry_bytes_cur = s1_start_reg ? 16'h0000 : carry_bytes_reg;
    assign carry_count_cur = s1_start_reg ? 2'd0     : carry_count_reg;
    assign pd_cur          = s1_start_reg ? 14'd0    : pixels_done_reg;

    scpf_pkg::pixel_t dec_px0, dec_px1;
    logic             dec_two;
    logic [15:0]      dec_carry_bytes;
    logic [1:0]       dec_carry_count;

    scpf_decode u_decode (
        .word             (s1_word_reg),
        .fmt              (pixel_format_reg),
        .carry_bytes      (carry_bytes_cur),
        .carry_count      (carry_count_cur),
        .px0              (dec_px0),
        .px1              (dec_px1),
        .made_two         (dec_two),
        .carry_bytes_next (dec_carry_bytes),
        .carry_count_next (dec_carry_count)
    );

    // Pixels still needed on this line decide how many of the word's pixels go out.
    logic        room;
    logic [13:0] remaining;
    logic        emit0, emit1;
    logic [1:0]  emit_count;

    assign room       = pd_cur < limit;
    assign remaining  = limit - pd_cur;
    assign emit0      = room;
    assign emit1      = room & dec_two & (remaining != 14'd1);
    assign emit_count = {1'b0, emit0} + {1'b0, emit1};

    scpf_pkg::pair_t load_pair;

    assign load_pair.px0 = dec_px0;
    assign load_pair.px1 = dec_px1;
    assign load_pair.le0 = (remaining == 14'd1);
    assign load_pair.le1 = (remaining == 14'd2);
    assign load_pair.two = emit1;

    always_comb
    begin
        carry_bytes_next = carry_bytes_reg;
        carry_count_next = carry_count_reg;
        pixels_done_next = pixels_done_reg;
        if (s1_adv)
        begin
            carry_bytes_next = dec_carry_bytes;
            carry_count_next = dec_carry_count;
            pixels_done_next = pd_cur + 14'(emit_count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_bytes_reg <= 16'h0000;
            carry_count_reg <= 2'd0;
            pixels_done_reg <= 14'd0;
        end
        else
        begin
            carry_bytes_reg <= carry_bytes_next;
            carry_count_reg <= carry_count_next;
            pixels_done_reg <= pixels_done_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register and output serializer
    // ------------------------------------------------------------------
    scpf_pkg::pixel_t out_pixel;

    scpf_serial u_serial (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (s1_adv & emit0),
        .load_pair      (load_pair),
        .free           (ser_free),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_pixel      (out_pixel),
        .out_line_end   (line_end),
        .out_burst_last (burst_last)
    );

    assign blue_value  = out_pixel.blue;
    assign green_value = out_pixel.green;
    assign red_value   = out_pixel.red;
    assign fourth_byte = out_pixel.fourth;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // At most two carried bytes in 24-bit mode.
    a_carry_le_two: assert property (@(posedge clk) disable iff (!rst_n)
        carry_count_reg != 2'd3)
        else $error("carry count out of range");

    // Carry survives only in packed 24-bit mode.
    a_carry_only_24: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && pixel_format_reg != scpf_pkg::FMT_RGB24 |=> carry_count_reg == 2'd0)
        else $error("carry kept outside 24-bit mode");

    // A line end on a word's pixel is always that word's last pixel.
    a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_end |-> burst_last)
        else $error("pixel after line end in same word");

    // Second pixel of a word follows right after the first is taken.
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !burst_last |=> out_valid)
        else $error("second pixel of word lost");

endmodule
